[hw/rtl/rmea_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmea_pkg
// shared constants and the arctangent table for the euler angle pipeline
// ----------------------------------------------------------------------------
package rmea_pkg;

  localparam int CORDIC_STEPS = 17;
  localparam int ZW           = 20;
  localparam int THR_W        = 15;

  localparam logic [0:0] REG_CONVENTION = 1'b0;
  localparam logic [0:0] REG_THRESHOLD  = 1'b1;

  localparam logic signed [ZW-1:0] PI_Q16 = 20'sd205887;

  function automatic logic signed [ZW-1:0] atan_q16(input int idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      0:       v = 20'sd51472;
      1:       v = 20'sd30385;
      2:       v = 20'sd16055;
      3:       v = 20'sd8150;
      4:       v = 20'sd4091;
      5:       v = 20'sd2047;
      6:       v = 20'sd1024;
      7:       v = 20'sd512;
      8:       v = 20'sd256;
      9:       v = 20'sd128;
      10:      v = 20'sd64;
      11:      v = 20'sd32;
      12:      v = 20'sd16;
      13:      v = 20'sd8;
      14:      v = 20'sd4;
      15:      v = 20'sd2;
      16:      v = 20'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/rmea_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmea_isqrt
// pipelined floor square root, one root bit per stage, side data carried along
// ----------------------------------------------------------------------------
module rmea_isqrt #(
  parameter int W      = 16,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [2*W-1:0]    n_in,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic      [W-1:0]      root_out,
  output logic      [SIDE_W-1:0] side_out
);

  localparam int RW = W + 3;

  logic [RW-1:0]     rem_r  [0:W];
  logic [W-1:0]      root_r [0:W];
  logic [2*W-1:0]    n_r    [0:W];
  logic [SIDE_W-1:0] side_r [0:W];

  always_comb begin
    rem_r[0]  = '0;
    root_r[0] = '0;
    n_r[0]    = n_in;
    side_r[0] = side_in;
  end

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [RW-1:0] cur;
    logic [RW-1:0] test;
    logic [RW-1:0] rem_nxt;
    logic [W-1:0]  root_nxt;

    always_comb begin
      cur  = {rem_r[k][RW-3:0], n_r[k][2*W-1 -: 2]};
      test = RW'({root_r[k], 2'b01});
      if (cur >= test) begin
        rem_nxt  = cur - test;
        root_nxt = {root_r[k][W-2:0], 1'b1};
      end else begin
        rem_nxt  = cur;
        root_nxt = {root_r[k][W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= root_nxt;
        n_r[k+1]    <= {n_r[k][2*W-3:0], 2'b00};
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign root_out = root_r[W];
  assign side_out = side_r[W];

endmodule
`default_nettype wire

[hw/rtl/rmea_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmea_cordic
// pipelined vectoring cordic atan2, quadrant fix-up stage then one step a stage
// ----------------------------------------------------------------------------
module rmea_cordic
  import rmea_pkg::*;
#(
  parameter int W = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [W:0]    y_in,
  input  wire logic signed [W:0]    x_in,
  output logic      signed [ZW-1:0] z_out
);

  localparam int CW = W + 16;

  logic signed [CW-1:0] x_r    [0:CORDIC_STEPS];
  logic signed [CW-1:0] y_r    [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_r    [0:CORDIC_STEPS];
  logic                 zero_r [0:CORDIC_STEPS];

  logic signed [CW-1:0] x_ext;
  logic signed [CW-1:0] y_ext;

  assign x_ext = CW'(x_in);
  assign y_ext = CW'(y_in);

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        z_r[0] <= (y_in >= 0) ? PI_Q16 : -PI_Q16;
        x_r[0] <= (-x_ext) <<< 12;
        y_r[0] <= (-y_ext) <<< 12;
      end else begin
        z_r[0] <= '0;
        x_r[0] <= x_ext <<< 12;
        y_r[0] <= y_ext <<< 12;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_q16(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_q16(i);
        end
      end
    end
  end

  assign z_out = zero_r[CORDIC_STEPS] ? '0 : z_r[CORDIC_STEPS];

endmodule
`default_nettype wire

[hw/rtl/rotation_matrix_to_euler_angles_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_core
// rotation matrix (q2.x) to three euler angles (q3.x radians) and a flag
// ----------------------------------------------------------------------------
// input beat: nine matrix elements on in_m00..in_m22 with in_valid/in_stall.
// output beat: out_angle_x/y/z and out_singular with out_valid/out_stall.
// cfg_we/cfg_index/cfg_wdata write convention (index 0) and the gimbal lock
// threshold (index 1); write only while the pipeline is empty.
// one beat is accepted every cycle while in_stall is low. the pipeline
// registers are operand select, squaring and sum, the square root pipe,
// the lock decision, the quadrant fix-up and step stages of the cordic pipes
// and the output register.
// reset clears all valid bits and sets convention 0, threshold 1.
// a stall while out_valid is high freezes the whole pipeline and is passed
// straight back on in_stall; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_angles_core
  import rmea_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [0:0]                   cfg_index,
  input  wire logic [THR_W-1:0]             cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [DATA_WIDTH-1:0] in_m00,
  input  wire logic signed [DATA_WIDTH-1:0] in_m01,
  input  wire logic signed [DATA_WIDTH-1:0] in_m02,
  input  wire logic signed [DATA_WIDTH-1:0] in_m10,
  input  wire logic signed [DATA_WIDTH-1:0] in_m11,
  input  wire logic signed [DATA_WIDTH-1:0] in_m12,
  input  wire logic signed [DATA_WIDTH-1:0] in_m20,
  input  wire logic signed [DATA_WIDTH-1:0] in_m21,
  input  wire logic signed [DATA_WIDTH-1:0] in_m22,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0]      out_angle_x,
  output logic signed [DATA_WIDTH-1:0]      out_angle_y,
  output logic signed [DATA_WIDTH-1:0]      out_angle_z,
  output logic                              out_singular
);

  localparam int W      = DATA_WIDTH;
  localparam int OW     = W + 1;
  localparam int SIDE_W = 7 * OW;
  localparam int CMPW   = (W > THR_W) ? W : THR_W;
  localparam int VLAT   = W;
  localparam int CLAT   = CORDIC_STEPS + 1;

  logic             conv_r;
  logic [THR_W-1:0] thr_r;
  logic             en;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_r <= 1'b0;
      thr_r  <= THR_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CONVENTION: conv_r <= cfg_wdata[0];
        REG_THRESHOLD:  thr_r  <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // operand select
  logic                 v1_r;
  logic signed [W-1:0]  a1_r, b1_r;
  logic [SIDE_W-1:0]    side1_r;
  logic signed [OW-1:0] yy_c, xny_c, xnx_c, xsy_c, xsx_c, zy_c, zx_c;

  always_comb begin
    if (!conv_r) begin
      yy_c  = -OW'(in_m20);
      xny_c = OW'(in_m21);
      xnx_c = OW'(in_m22);
      xsy_c = -OW'(in_m12);
      xsx_c = OW'(in_m11);
      zy_c  = OW'(in_m10);
    end else begin
      yy_c  = OW'(in_m02);
      xny_c = -OW'(in_m12);
      xnx_c = OW'(in_m22);
      xsy_c = OW'(in_m21);
      xsx_c = OW'(in_m11);
      zy_c  = -OW'(in_m01);
    end
    zx_c = OW'(in_m00);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r    <= in_m00;
      b1_r    <= conv_r ? in_m01 : in_m10;
      side1_r <= {yy_c, xny_c, xnx_c, xsy_c, xsx_c, zy_c, zx_c};
    end
  end

  // squares
  logic                  v2_r;
  logic signed [2*W-1:0] sqa2_r, sqb2_r;
  logic [SIDE_W-1:0]     side2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqa2_r  <= a1_r * a1_r;
      sqb2_r  <= b1_r * b1_r;
      side2_r <= side1_r;
    end
  end

  // sum
  logic              v3_r;
  logic [2*W-1:0]    sum3_r;
  logic [SIDE_W-1:0] side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum3_r  <= unsigned'(sqa2_r) + unsigned'(sqb2_r);
      side3_r <= side2_r;
    end
  end

  // square root
  logic [W-1:0]      sy;
  logic [SIDE_W-1:0] side_s;
  logic [VLAT-1:0]   vs_r;

  rmea_isqrt #(.W(W), .SIDE_W(SIDE_W)) u_isqrt (
    .clk      (clk),
    .en       (en),
    .n_in     (sum3_r),
    .side_in  (side3_r),
    .root_out (sy),
    .side_out (side_s)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= '0;
    end else if (en) begin
      vs_r <= {vs_r[VLAT-2:0], v3_r};
    end
  end

  // lock decision
  logic signed [OW-1:0] s_yy, s_xny, s_xnx, s_xsy, s_xsx, s_zy, s_zx;
  logic                 sing_c;
  logic signed [OW-1:0] ay_y_r, ay_x_r, ax_y_r, ax_x_r, az_y_r, az_x_r;

  assign {s_yy, s_xny, s_xnx, s_xsy, s_xsx, s_zy, s_zx} = side_s;
  assign sing_c = CMPW'(sy) < CMPW'(thr_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ay_y_r <= s_yy;
      ay_x_r <= OW'(sy);
      ax_y_r <= sing_c ? s_xsy : s_xny;
      ax_x_r <= sing_c ? s_xsx : s_xnx;
      az_y_r <= sing_c ? '0 : s_zy;
      az_x_r <= sing_c ? '0 : s_zx;
    end
  end

  // valid and flag line alongside the cordic pipes
  logic [CLAT:0] vc_r;
  logic [CLAT:0] sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= '0;
    end else if (en) begin
      vc_r <= {vc_r[CLAT-1:0], vs_r[VLAT-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r <= {sc_r[CLAT-1:0], sing_c};
    end
  end

  logic signed [ZW-1:0] zx, zy, zz;

  rmea_cordic #(.W(W)) u_cordic_x (
    .clk (clk), .en (en), .y_in (ax_y_r), .x_in (ax_x_r), .z_out (zx)
  );

  rmea_cordic #(.W(W)) u_cordic_y (
    .clk (clk), .en (en), .y_in (ay_y_r), .x_in (ay_x_r), .z_out (zy)
  );

  rmea_cordic #(.W(W)) u_cordic_z (
    .clk (clk), .en (en), .y_in (az_y_r), .x_in (az_x_r), .z_out (zz)
  );

  // output format
  logic signed [W-1:0] fx, fy, fz;

  if (W < 19) begin : g_round
    localparam int RS = 19 - W;
    logic signed [ZW:0] tx, ty, tz, rx, ry, rz;
    assign tx = (ZW+1)'(zx) + (ZW+1)'(1 << (RS - 1));
    assign ty = (ZW+1)'(zy) + (ZW+1)'(1 << (RS - 1));
    assign tz = (ZW+1)'(zz) + (ZW+1)'(1 << (RS - 1));
    assign rx = tx >>> RS;
    assign ry = ty >>> RS;
    assign rz = tz >>> RS;
    assign fx = rx[W-1:0];
    assign fy = ry[W-1:0];
    assign fz = rz[W-1:0];
  end else if (W == 19) begin : g_same
    assign fx = zx[W-1:0];
    assign fy = zy[W-1:0];
    assign fz = zz[W-1:0];
  end else begin : g_widen
    localparam int LS = W - 19;
    logic signed [ZW+LS-1:0] tx, ty, tz;
    assign tx = {zx, {LS{1'b0}}};
    assign ty = {zy, {LS{1'b0}}};
    assign tz = {zz, {LS{1'b0}}};
    assign fx = tx[W-1:0];
    assign fy = ty[W-1:0];
    assign fz = tz[W-1:0];
  end

  logic                valid_r;
  logic signed [W-1:0] ang_x_r, ang_y_r, ang_z_r;
  logic                sing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= vc_r[CLAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_x_r <= fx;
      ang_y_r <= fy;
      ang_z_r <= fz;
      sing_r  <= sc_r[CLAT];
    end
  end

  assign out_valid    = valid_r;
  assign out_angle_x  = ang_x_r;
  assign out_angle_y  = ang_y_r;
  assign out_angle_z  = ang_z_r;
  assign out_singular = sing_r;

endmodule
`default_nettype wire

[tb/rotation_matrix_to_euler_angles_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_checker
// predicts the euler angles of every accepted input beat and compares them
// in order with the output beats of the core, counting mismatches
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_angles_checker
  import rmea_pkg::*;
#(
  parameter int DW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [0:0]           cfg_index,
  input  wire logic [THR_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic signed [DW-1:0] in_m00,
  input  wire logic signed [DW-1:0] in_m01,
  input  wire logic signed [DW-1:0] in_m02,
  input  wire logic signed [DW-1:0] in_m10,
  input  wire logic signed [DW-1:0] in_m11,
  input  wire logic signed [DW-1:0] in_m12,
  input  wire logic signed [DW-1:0] in_m20,
  input  wire logic signed [DW-1:0] in_m21,
  input  wire logic signed [DW-1:0] in_m22,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic signed [DW-1:0] out_angle_x,
  input  wire logic signed [DW-1:0] out_angle_y,
  input  wire logic signed [DW-1:0] out_angle_z,
  input  wire logic                 out_singular,
  output int                        errors,
  output int                        pending
);

  typedef struct packed {
    logic [DW-1:0] ax;
    logic [DW-1:0] ay;
    logic [DW-1:0] az;
    logic          sing;
  } angles_t;

  angles_t       angle_q[$];
  logic          conv_r;
  logic [THR_W-1:0] thr_r;

  initial pending = 0;

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan2_q16(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q16) : -longint'(PI_Q16);
      x = -x;
      y = -y;
    end
    x = x * 4096;
    y = y * 4096;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = sra(x, i);
      ys = sra(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(atan_q16(i));
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(atan_q16(i));
      end
    end
    return z;
  endfunction

  function automatic logic [DW-1:0] to_angle(longint z);
    int f;
    longint r;
    f = DW - 3;
    if (f <= 16) begin
      r = (f == 16) ? z : sra(z + (longint'(1) << (15 - f)), 16 - f);
    end else begin
      r = z <<< (f - 16);
    end
    return r[DW-1:0];
  endfunction

  function automatic longint root_floor(longint n);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b); r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic angles_t euler_of(longint a00, longint a01, longint a02,
                                       longint a10, longint a11, longint a12,
                                       longint a20, longint a21, longint a22);
    angles_t e;
    longint sec, sy, ax, ay, az;
    logic sing;
    sec = conv_r ? a01 : a10;
    sy = root_floor(a00 * a00 + sec * sec);
    sing = sy < longint'(thr_r);
    if (!conv_r) begin
      ay = atan2_q16(-a20, sy);
      if (!sing) begin
        ax = atan2_q16(a21, a22); az = atan2_q16(a10, a00);
      end else begin
        ax = atan2_q16(-a12, a11); az = 0;
      end
    end else begin
      ay = atan2_q16(a02, sy);
      if (!sing) begin
        ax = atan2_q16(-a12, a22); az = atan2_q16(-a01, a00);
      end else begin
        ax = atan2_q16(a21, a11); az = 0;
      end
    end
    e.ax = to_angle(ax);
    e.ay = to_angle(ay);
    e.az = to_angle(az);
    e.sing = sing;
    return e;
  endfunction

  always @(posedge clk) begin
    angles_t got, want;
    if (!rst_n) begin
      conv_r <= 1'b0;
      thr_r  <= THR_W'(1);
      errors <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CONVENTION) conv_r <= cfg_wdata[0];
        else thr_r <= cfg_wdata;
      end
      if (in_valid && !in_stall)
        angle_q.push_back(euler_of(in_m00, in_m01, in_m02, in_m10, in_m11,
                                   in_m12, in_m20, in_m21, in_m22));
      if (out_valid && !out_stall) begin
        got = '{out_angle_x, out_angle_y, out_angle_z, out_singular};
        if (angle_q.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = angle_q.pop_front();
          if (got.ax !== want.ax)
            $display("%0t: angle_x expected %h actual %h", $time, want.ax, got.ax);
          if (got.ay !== want.ay)
            $display("%0t: angle_y expected %h actual %h", $time, want.ay, got.ay);
          if (got.az !== want.az)
            $display("%0t: angle_z expected %h actual %h", $time, want.az, got.az);
          if (got.sing !== want.sing)
            $display("%0t: singular expected %b actual %b", $time, want.sing, got.sing);
          if (got !== want) errors <= errors + 1;
        end
      end
    end
    pending <= angle_q.size();
  end

endmodule

[tb/rotation_matrix_to_euler_angles_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_core_test
// drives directed and random matrices through the core in bursts, under a
// random output stall, across both conventions and several thresholds
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_angles_core_test;
  import rmea_pkg::*;

  localparam int DW = 16;
  localparam int LAT = DW + 23;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_CONVENTION;
  logic [THR_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DW-1:0] m [9];
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DW-1:0] out_angle_x, out_angle_y, out_angle_z;
  logic out_singular;
  int errors, pending;
  int idle_cycles = 0;
  bit stall_mode = 1'b0;

  initial for (int i = 0; i < 9; i++) m[i] = '0;

  always #5 clk = ~clk;

  rotation_matrix_to_euler_angles_core #(.DATA_WIDTH(DW)) dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .in_valid, .in_stall,
    .in_m00(m[0]), .in_m01(m[1]), .in_m02(m[2]), .in_m10(m[3]), .in_m11(m[4]),
    .in_m12(m[5]), .in_m20(m[6]), .in_m21(m[7]), .in_m22(m[8]),
    .out_valid, .out_stall, .out_angle_x, .out_angle_y, .out_angle_z,
    .out_singular
  );

  rotation_matrix_to_euler_angles_checker #(.DW(DW)) checker_i (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .in_valid, .in_stall,
    .in_m00(m[0]), .in_m01(m[1]), .in_m02(m[2]), .in_m10(m[3]), .in_m11(m[4]),
    .in_m12(m[5]), .in_m20(m[6]), .in_m21(m[7]), .in_m22(m[8]),
    .out_valid, .out_stall, .out_angle_x, .out_angle_y, .out_angle_z,
    .out_singular, .errors, .pending
  );

  // receiver stall pattern: quiet stretches and busy stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    out_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [THR_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (LAT + 4) @(negedge clk);
  endtask

  // one beat; called at a falling edge, returns at a falling edge
  task automatic send_matrix(input logic signed [DW-1:0] v [9]);
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) m[i] <= v[i];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  function automatic logic signed [DW-1:0] rnd_elem();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return DW'($signed($urandom_range(0, 64)) - 32);
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic run_random(input int n);
    logic signed [DW-1:0] v [9];
    int burst;
    int c, s;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      if (burst == 0) begin
        gap();
        burst = $urandom_range(1, 40);
      end
      burst--;
      if ($urandom_range(0, 3) != 0) begin
        // rotation-like matrix from a rough cos/sin pair
        c = $urandom_range(0, 16384);
        s = 16384 - c;
        for (int i = 0; i < 9; i++) v[i] = DW'($signed($urandom_range(0, 32768)) - 16384);
        v[0] = $urandom_range(0, 1) ? DW'(c) : -DW'(c);
        v[3] = $urandom_range(0, 1) ? DW'(s) : -DW'(s);
        v[1] = $urandom_range(0, 1) ? DW'(s) : -DW'(s);
        if ($urandom_range(0, 7) == 0) begin
          v[0] = DW'($signed($urandom_range(0, 6)) - 3);
          v[1] = DW'($signed($urandom_range(0, 6)) - 3);
          v[3] = DW'($signed($urandom_range(0, 6)) - 3);
        end
      end else begin
        for (int i = 0; i < 9; i++) v[i] = rnd_elem();
      end
      send_matrix(v);
    end
    in_valid <= 1'b0;
  endtask

  task automatic run_directed();
    logic signed [DW-1:0] v [9];
    for (int p = 0; p < 12; p++) begin
      for (int i = 0; i < 9; i++) begin
        case (p)
          0: v[i] = '0;
          1: v[i] = 16'sh7fff;
          2: v[i] = 16'sh8000;
          3: v[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;
          4: v[i] = (i % 4 == 0) ? -16'sd16384 : 16'sd0;
          5: v[i] = (i == 6) ? -16'sd16384 : (i == 7 || i == 5) ? 16'sd16384 : 16'sd0;
          6: v[i] = (i == 6) ? 16'sd16384 : (i == 4) ? -16'sd16384 : 16'sd0;
          7: v[i] = (i == 0 || i == 1 || i == 3) ? 16'sd1 : 16'sh5555;
          8: v[i] = (i == 0) ? -16'sd1 : (i == 2) ? 16'sh7fff : 16'shaaaa;
          9: v[i] = (i == 0) ? -16'sd16384 : (i == 3 || i == 1) ? 16'sd0 : -16'sd1;
          10: v[i] = (i == 0) ? -16'sd16384 : (i == 3 || i == 1) ? -16'sd1 : 16'sd1;
          default: v[i] = (i % 2) ? 16'sh8000 : 16'sh7fff;
        endcase
      end
      send_matrix(v);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    drain();
    write_reg(REG_CONVENTION, 15'd1);
    run_directed();
    drain();
    write_reg(REG_THRESHOLD, 15'h7fff);
    run_directed();
    drain();
    write_reg(REG_THRESHOLD, 15'd0);
    write_reg(REG_CONVENTION, 15'd0);
    run_random(250);
    drain();
    write_reg(REG_THRESHOLD, 15'd4);
    run_random(250);
    drain();
    write_reg(REG_CONVENTION, 15'd1);
    run_random(250);
    drain();
    write_reg(REG_THRESHOLD, 15'h7fff);
    run_random(200);
    drain();
    write_reg(REG_THRESHOLD, 15'd8000);
    write_reg(REG_CONVENTION, 15'd0);
    run_random(250);
    drain();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
